// ----- rtl/fpod_pkg.sv -----
package fpod_pkg;

  typedef enum logic [2:0] {
    OP_DIS = 3'd0,
    OP_EQ  = 3'd1,
    OP_NEQ = 3'd2,
    OP_GT  = 3'd3,
    OP_GE  = 3'd4,
    OP_LT  = 3'd5,
    OP_LE  = 3'd6,
    OP_RSV = 3'd7
  } opcode_e;

  localparam logic [63:0] SignBit  = 64'h8000000000000000;
  localparam logic [63:0] MagMask  = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [62:0] ExpInf   = 63'h7FF0000000000000;
  localparam logic [63:0] BitsZero = 64'h0000000000000000;
  localparam logic [63:0] BitsOne  = 64'h3FF0000000000000;
  localparam logic [63:0] Bits1024 = 64'h4090000000000000;
  localparam logic [63:0] BitsDmin = 64'h0010000000000000;
  localparam int unsigned ScaleLog2 = 54;

  // Decisions made in the first stage that ride along with the integer
  typedef struct packed {
    logic        force_en;  // result is a fixed code, not the converted integer
    logic [63:0] force_val;
  } ctl_t;

  // Position of the leading one in a 64-bit word (0 when zero)
  function automatic logic [5:0] lead_one(input logic [63:0] x);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

// ----- rtl/fpod_if.sv -----
interface fpod_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] a_bits;
  logic [63:0] b_bits;
  modport source (output valid, opcode, a_bits, b_bits, input ready);
  modport sink (input valid, opcode, a_bits, b_bits, output ready);
endinterface

interface fpod_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] distance_bits;
  modport source (output valid, distance_bits, input ready);
  modport sink (input valid, distance_bits, output ready);
endinterface

// ----- rtl/fpod_classify.sv -----
module fpod_classify (
  input  logic [2:0]     opcode_i,
  input  logic [63:0]    a_bits_i,
  input  logic [63:0]    b_bits_i,
  output fpod_pkg::ctl_t ctl_o,
  output logic [63:0]    int_o
);

  logic        nan_a, nan_b, nan, eq, gt_ab, gt_ba, diff_sign;
  logic [62:0] ma, mb;
  logic [63:0] ka, kb, base_const;
  logic        base_is_const;

  // Classify operands and build the ordering keys
  always_comb begin
    ma = a_bits_i[62:0];
    mb = b_bits_i[62:0];
    nan_a = ma > fpod_pkg::ExpInf;
    nan_b = mb > fpod_pkg::ExpInf;
    nan = nan_a | nan_b;
    eq = !nan && ((a_bits_i == b_bits_i) || ((ma | mb) == 63'd0));
    ka = a_bits_i[63] ? ~a_bits_i : (a_bits_i | fpod_pkg::SignBit);
    kb = b_bits_i[63] ? ~b_bits_i : (b_bits_i | fpod_pkg::SignBit);
    gt_ab = ka > kb;
    gt_ba = kb > ka;
    diff_sign = a_bits_i[63] ^ b_bits_i[63];
    if (diff_sign) int_o = {1'b0, ma} + {1'b0, mb};
    else if (ma > mb) int_o = {1'b0, ma - mb};
    else int_o = {1'b0, mb - ma};
    base_is_const = eq | nan;
    base_const = eq ? fpod_pkg::BitsZero : fpod_pkg::Bits1024;
  end

  // Apply the opcode
  always_comb begin
    ctl_o.force_en = base_is_const;
    ctl_o.force_val = base_const;
    case (fpod_pkg::opcode_e'(opcode_i))
      fpod_pkg::OP_NEQ: begin
        ctl_o.force_en = 1'b1;
        ctl_o.force_val = eq ? fpod_pkg::BitsOne : fpod_pkg::BitsZero;
      end
      fpod_pkg::OP_GT, fpod_pkg::OP_LT: begin
        if (eq) begin
          ctl_o.force_en = 1'b1;
          ctl_o.force_val = fpod_pkg::BitsDmin;
        end else if (!nan && (opcode_i == fpod_pkg::OP_GT ? gt_ab : gt_ba)) begin
          ctl_o.force_en = 1'b1;
          ctl_o.force_val = fpod_pkg::BitsZero;
        end
      end
      fpod_pkg::OP_GE, fpod_pkg::OP_LE: begin
        if (eq || (!nan && (opcode_i == fpod_pkg::OP_GE ? gt_ab : gt_ba))) begin
          ctl_o.force_en = 1'b1;
          ctl_o.force_val = fpod_pkg::BitsZero;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/fpod_round.sv -----
module fpod_round (
  input  logic [63:0] int_i,
  input  logic [5:0]  lead_i,
  output logic [63:0] bits_o
);

  logic [63:0] norm, keep;
  logic        guard, sticky, inc;
  logic [63:0] expo;

  // Normalize so the leading one sits at bit 63, then round at bit 11
  always_comb begin
    norm = int_i << (6'd63 - lead_i);
    guard = norm[10];
    sticky = |norm[9:0];
    inc = guard && (sticky || norm[11]);
    keep = {11'd0, norm[63:11]} + {63'd0, inc};
    expo = {52'd0, 12'(lead_i) + 12'(1022 - fpod_pkg::ScaleLog2)} << 52;
    bits_o = (int_i == 64'd0) ? fpod_pkg::BitsZero : expo + keep;
  end

endmodule

// ----- rtl/fp64_ordered_distance.sv -----
// Pipeline stages: classify, leading-one, round; each ends in a register.
// Throughput: one beat per cycle; a stalled output holds all stages in place.
// Reset: rst_ni asynchronous active low clears the stage valid bits only.
// The datapath keeps no state between beats.
module fp64_ordered_distance (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpod_in_if.sink    in_i,
  fpod_out_if.source out_o
);

  logic           adv;
  fpod_pkg::ctl_t ctl_c, ctl1_q, ctl2_q;
  logic [63:0]    int_c, int1_q, int2_q, res_c, res_q;
  logic [5:0]     lead_c, lead2_q;
  logic           v1_q, v2_q, v3_q;

  // Whole pipe advances unless the output stage is full and stalled
  assign adv = !v3_q || out_o.ready;
  assign in_i.ready = adv;

  fpod_classify u_cls (
    .opcode_i(in_i.opcode), .a_bits_i(in_i.a_bits), .b_bits_i(in_i.b_bits),
    .ctl_o(ctl_c), .int_o(int_c)
  );

  assign lead_c = fpod_pkg::lead_one(int1_q);

  fpod_round u_rnd (.int_i(int2_q), .lead_i(lead2_q), .bits_o(res_c));

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl1_q <= ctl_c;
      int1_q <= int_c;
      ctl2_q <= ctl1_q;
      int2_q <= int1_q;
      lead2_q <= lead_c;
      res_q <= ctl2_q.force_en ? ctl2_q.force_val : res_c;
    end
  end

  assign out_o.valid = v3_q;
  assign out_o.distance_bits = res_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.distance_bits))
    else $error("output beat changed under stall");
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !out_o.distance_bits[63])
    else $error("negative distance");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted beat lost in stage one");
`endif

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpod_in_if  in_if ();
  fpod_out_if out_if ();

  fp64_ordered_distance dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  localparam int WatchdogLimit = 20000;

  logic [63:0] distance_q[$];
  int          n_errors    = 0;
  int          send_idle   = 0;
  int          recv_idle   = 0;
  int          quiet_count = 0;

  always #10 clk_i = ~clk_i;

  initial begin
    in_if.valid  = 1'b0;
    in_if.opcode = '0;
    in_if.a_bits = '0;
    in_if.b_bits = '0;
    out_if.ready = 1'b0;
  end

  // Predictor: IEEE compare and scaled magnitude-code distance
  function automatic bit fp_is_nan(logic [63:0] x);
    return (x & fpod_pkg::MagMask) > {1'b0, fpod_pkg::ExpInf};
  endfunction

  function automatic bit fp_equal(logic [63:0] a, logic [63:0] b);
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    return (a == b) || (((a | b) & fpod_pkg::MagMask) == 64'd0);
  endfunction

  function automatic logic [63:0] order_code(logic [63:0] x);
    return x[63] ? ~x : (x | fpod_pkg::SignBit);
  endfunction

  function automatic logic [63:0] scale_count(logic [63:0] u);
    int          p;
    int          sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    if (u == 64'd0) return fpod_pkg::BitsZero;
    p = 63;
    while (!u[p]) p--;
    if (p <= 52) begin
      keep = u << (52 - p);
    end else begin
      sh   = p - 52;
      rem  = u & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      keep = u >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
    end
    return (64'(p + 1022 - fpod_pkg::ScaleLog2) << 52) + keep;
  endfunction

  function automatic logic [63:0] base_gap(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    ma = a & fpod_pkg::MagMask;
    mb = b & fpod_pkg::MagMask;
    if (fp_equal(a, b)) return fpod_pkg::BitsZero;
    if (fp_is_nan(a) || fp_is_nan(b)) return fpod_pkg::Bits1024;
    if (a[63] != b[63]) return scale_count(ma + mb);
    return scale_count(ma > mb ? ma - mb : mb - ma);
  endfunction

  function automatic logic [63:0] predict_distance(fpod_pkg::opcode_e op,
                                                   logic [63:0] a,
                                                   logic [63:0] b);
    bit eq;
    bit nan;
    bit holds;
    eq  = fp_equal(a, b);
    nan = fp_is_nan(a) || fp_is_nan(b);
    case (op)
      fpod_pkg::OP_EQ:  return eq ? fpod_pkg::BitsZero : base_gap(a, b);
      fpod_pkg::OP_NEQ: return eq ? fpod_pkg::BitsOne : fpod_pkg::BitsZero;
      fpod_pkg::OP_GT, fpod_pkg::OP_LT: begin
        holds = !eq && !nan && (op == fpod_pkg::OP_GT ? order_code(a) > order_code(b)
                                                      : order_code(b) > order_code(a));
        if (holds) return fpod_pkg::BitsZero;
        if (eq) return fpod_pkg::BitsDmin;
        return base_gap(a, b);
      end
      fpod_pkg::OP_GE, fpod_pkg::OP_LE: begin
        holds = eq || (!nan && (op == fpod_pkg::OP_GE ? order_code(a) > order_code(b)
                                                      : order_code(b) > order_code(a)));
        return holds ? fpod_pkg::BitsZero : base_gap(a, b);
      end
      default: return base_gap(a, b);
    endcase
  endfunction

  // Send one beat, idling first at the configured rate; valid stays high after
  task automatic send_pair(fpod_pkg::opcode_e op, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.a_bits <= a;
    in_if.b_bits <= b;
    distance_q.push_back(predict_distance(op, a, b));
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Receiver stall and result check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (distance_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected beat %h", out_if.distance_bits);
        end else begin
          if (out_if.distance_bits !== distance_q[0]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected %h actual %h", distance_q[0],
                       out_if.distance_bits);
          end
          void'(distance_q.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= WatchdogLimit) begin
      $display("fp64_ordered_distance regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] random_operand();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(7))
      0: x[62:52] = 11'h7FF;
      1: x[62:52] = 11'h000;
      2: x[62:0]  = '0;
      default: ;
    endcase
    return x;
  endfunction

  task automatic test_directed();
    logic [63:0] edges[10];
    edges = '{64'h0, fpod_pkg::SignBit, 64'h7FF0000000000000, 64'hFFF0000000000000,
              64'h7FF8000000000000, 64'h7FF0000000000001, 64'h0000000000000001,
              64'h7FEFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, fpod_pkg::BitsOne};
    for (int o = 0; o < 8; o++) begin
      send_pair(fpod_pkg::opcode_e'(o), 64'h0, fpod_pkg::SignBit);
      send_pair(fpod_pkg::opcode_e'(o), fpod_pkg::BitsOne, 64'h4000000000000000);
      send_pair(fpod_pkg::opcode_e'(o), 64'h7FF8000000000000, fpod_pkg::BitsOne);
    end
    for (int i = 0; i < 10; i++)
      send_pair(fpod_pkg::opcode_e'($urandom_range(7)), edges[i],
                edges[(i * 3 + 1) % 10]);
    // rounding: sign differs with a large sum of codes, then an exact tie
    send_pair(fpod_pkg::OP_DIS, 64'h7FEFFFFFFFFFFFFF, 64'hFFEFFFFFFFFFFFFF);
    send_pair(fpod_pkg::OP_DIS, 64'h0020000000000001, 64'h0);
  endtask

  task automatic test_random(int count);
    logic [63:0] a;
    logic [63:0] b;
    for (int i = 0; i < count; i++) begin
      a = random_operand();
      case ($urandom_range(3))
        0: b = a ^ 64'(1 << $urandom_range(5));
        1: b = a ^ fpod_pkg::SignBit;
        default: b = random_operand();
      endcase
      send_pair(fpod_pkg::opcode_e'($urandom_range(7)), a, b);
    end
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 8;
    recv_idle = 82;
    test_directed();
    test_random(250);
    drain_results();
    send_idle = 82;
    recv_idle = 8;
    test_random(250);
    send_idle = 0;
    recv_idle = 0;
    test_random(250);
    drain_results();
    repeat (10) @(posedge clk_i);
    if (n_errors == 0)
      $display("fp64_ordered_distance regression: pass");
    else
      $display("fp64_ordered_distance regression: fail");
    $finish;
  end

endmodule

// ----- fp64_ordered_distance.f -----
rtl/fpod_pkg.sv
rtl/fpod_if.sv
rtl/fpod_classify.sv
rtl/fpod_round.sv
rtl/fp64_ordered_distance.sv
verif/tb_top.sv
